// ===== hw/rtl/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types and constants for the Prewitt edge magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package pem_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 7;
  localparam int OFS_W   = 9;
  localparam int GRAD_W  = 11;
  localparam int SQ_W    = 2 * (GRAD_W - 1);
  localparam int SUM_W   = SQ_W + 1;
  localparam int ROOT_IN_W = 16;
  localparam int ROOT_STEPS = ROOT_IN_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int REM_W   = PIX_W + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65280);
  localparam logic [PIX_W-1:0] PIX_MAX   = '1;

  typedef logic [PIX_W-1:0]         pixel_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic signed [OFS_W-1:0]  offset_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam dim_t    WIDTH_RST  = DIM_W'(16);
  localparam dim_t    HEIGHT_RST = DIM_W'(16);
  localparam offset_t OFFSET_RST = OFS_W'(3);

endpackage

`default_nettype wire

// ===== hw/rtl/pem_pix_if.sv =====
// ----------------------------------------------------------------------------
// pem_pix_if
// Pixel stream channel: valid/ready handshake with one grayscale pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pem_pix_if import pem_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pem_res_if.sv =====
// ----------------------------------------------------------------------------
// pem_res_if
// Result channel: valid/ready handshake with magnitude, position and run end.
// ----------------------------------------------------------------------------
`default_nettype none

interface pem_res_if import pem_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t edge_value;
  row_t   out_row;
  col_t   out_col;
  logic   run_end;

  modport source (output valid, output edge_value, output out_row, output out_col,
                  output run_end, input ready);
  modport sink   (input valid, input edge_value, input out_row, input out_col,
                  input run_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pem_root.sv =====
// ----------------------------------------------------------------------------
// pem_root
// Rounded integer square root of a 16-bit value, two operand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_root import pem_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [ROOT_IN_W-1:0] operand,
  output      logic                 done,
  output      pixel_t               root
);

  logic [ROOT_IN_W-1:0]  op_r,  op_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  pixel_t                q_r,   q_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  assign rem_t = {rem_r, op_r[ROOT_IN_W-1 -: 2]};
  assign trial = {1'b0, q_r, 2'b01};
  assign diff  = rem_t - trial;
  assign fits  = (rem_t >= trial);

  always_comb begin
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      op_nxt   = operand;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      op_nxt  = {op_r[ROOT_IN_W-3:0], 2'b00};
      rem_nxt = fits ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
      q_nxt   = {q_r[PIX_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  // remainder above the floor root means the value lies past r*r + r: round up
  assign done = done_r;
  assign root = q_r + PIX_W'(rem_r > {1'b0, q_r});

endmodule

`default_nettype wire

// ===== hw/rtl/prewitt_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude
// Prewitt gradient magnitude over a raster-scanned 8-bit image, 3x3 window,
// replicated borders, rounded and saturated square root of gx^2 + gy^2.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  in_pix    | in        | valid/ready          | pixel
//  out_res   | out       | valid/ready          | edge_value, out_row, out_col, run_end
//  apb       | in        | psel/penable/pready  | paddr, pwdata, prdata
//
//  A pixel is accepted, then passes a line-store read-modify-write; each result
//  it completes (0 to 4) then takes a gradient, squares, sum, 8 steps of the
//  shared root unit and its done strobe, and an output load.
//  Pixels are taken one at a time; a waiting output beat stalls only the next load.
//  Synchronous active-low reset clears control state, window and registers.
//  The line store needs no clearing pass: unwritten entries never reach a result.
// ----------------------------------------------------------------------------
`default_nettype none

module prewitt_edge_magnitude import pem_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  pem_pix_if.sink                 in_pix,
  pem_res_if.source               out_res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  // ---------------- configuration ----------------
  dim_t    width_r, height_r;
  offset_t ofs_r;
  logic    cfg_wr;
  dim_t    eff_w, eff_h;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      ofs_r    <= OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_OFFSET: ofs_r    <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = PDATA_W'(width_r);
      REG_HEIGHT: prdata = PDATA_W'(height_r);
      REG_OFFSET: prdata = PDATA_W'($signed(ofs_r));
      default:    prdata = '0;
    endcase
  end

  assign eff_w = (width_r < DIM_W'(2)) ? DIM_W'(2) :
                 (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
  assign eff_h = (height_r < DIM_W'(2)) ? DIM_W'(2) :
                 (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;

  // ---------------- control state ----------------
  logic [2:0] state_r, state_nxt;
  row_t       row_r, row_nxt;
  col_t       col_r, col_nxt;
  row_t       ra_r;
  col_t       ca_r;
  pixel_t     px_r;
  logic [3:0] mask_r, mask_nxt;
  logic       top_r, left_r;

  logic   in_go;
  row_t   cur_r;
  col_t   cur_c;
  logic   cur_last_c, cur_last_r;

  assign in_pix.ready = (state_r == S_IDLE);
  assign in_go        = in_pix.valid && in_pix.ready;

  always_comb begin
    if ((DIM_W'(row_r) >= eff_h) || (DIM_W'(col_r) >= eff_w)) begin
      cur_r = '0;
      cur_c = '0;
    end else begin
      cur_r = row_r;
      cur_c = col_r;
    end
  end
  assign cur_last_c = (DIM_W'(cur_c) == eff_w - 1'b1);
  assign cur_last_r = (DIM_W'(cur_r) == eff_h - 1'b1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT))) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_go) begin
      if (cur_last_c) begin
        col_nxt = '0;
        row_nxt = cur_last_r ? '0 : cur_r + 1'b1;
      end else begin
        col_nxt = cur_c + 1'b1;
        row_nxt = cur_r;
      end
    end
  end

  // ---------------- line store: {older row, previous row} per column ----------
  // Read at accept, written back in the following cycle; the next read waits for idle.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_q_r;

  always_ff @(posedge clk) begin
    if (in_go) begin
      line_q_r <= line_mem[cur_c];
    end
    if (state_r == S_READ) begin
      line_mem[ca_r] <= {line_q_r[PIX_W-1:0], px_r};
    end
  end

  // ---------------- window [column][row], column 2 newest ----------------
  pixel_t win_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (state_r == S_READ) begin
      for (int j = 0; j < 3; j++) begin
        win_r[0][j] <= win_r[1][j];
        win_r[1][j] <= win_r[2][j];
      end
      win_r[2][0] <= line_q_r[2*PIX_W-1:PIX_W];
      win_r[2][1] <= line_q_r[PIX_W-1:0];
      win_r[2][2] <= px_r;
    end
  end

  // results due for this pixel, in raster order
  logic [3:0] need;
  logic       ra_last_c, ra_last_r;

  assign ra_last_c = (DIM_W'(ca_r) == eff_w - 1'b1);
  assign ra_last_r = (DIM_W'(ra_r) == eff_h - 1'b1);

  always_comb begin
    need    = '0;
    need[0] = (ra_r != '0) && (ca_r != '0);
    need[1] = (ra_r != '0) && ra_last_c;
    need[2] = (ra_r != '0) && ra_last_r && (ca_r != '0);
    need[3] = (ra_r != '0) && ra_last_r && ra_last_c;
  end

  // ---------------- gradient of the lowest pending result ----------------
  logic [1:0] slot;
  logic [1:0] rsel [3];
  logic [1:0] csel [3];
  logic [PIX_W+1:0] bot_sum, top_sum, rgt_sum, lft_sum;
  grad_t      gx, gy;
  grad_t      gx_r, gy_r;
  row_t       orow, orow_r;
  col_t       ocol, ocol_r;
  logic       last_r;

  always_comb begin
    if (mask_r[0])      slot = 2'd0;
    else if (mask_r[1]) slot = 2'd1;
    else if (mask_r[2]) slot = 2'd2;
    else                slot = 2'd3;
  end

  always_comb begin
    // the last row repeats the bottom row, the last column the right column
    rsel[0] = slot[1] ? 2'd1 : {1'b0, top_r};
    rsel[1] = slot[1] ? 2'd2 : 2'd1;
    rsel[2] = 2'd2;
    csel[0] = slot[0] ? 2'd1 : {1'b0, left_r};
    csel[1] = slot[0] ? 2'd2 : 2'd1;
    csel[2] = 2'd2;
    orow    = slot[1] ? ra_r : ra_r - 1'b1;
    ocol    = slot[0] ? ca_r : ca_r - 1'b1;
  end

  always_comb begin
    bot_sum = '0;
    top_sum = '0;
    rgt_sum = '0;
    lft_sum = '0;
    for (int i = 0; i < 3; i++) begin
      bot_sum = bot_sum + (PIX_W+2)'(win_r[csel[i]][rsel[2]]);
      top_sum = top_sum + (PIX_W+2)'(win_r[csel[i]][rsel[0]]);
      rgt_sum = rgt_sum + (PIX_W+2)'(win_r[csel[2]][rsel[i]]);
      lft_sum = lft_sum + (PIX_W+2)'(win_r[csel[0]][rsel[i]]);
    end
    gx = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum}) + GRAD_W'(ofs_r);
    gy = $signed({1'b0, rgt_sum}) - $signed({1'b0, lft_sum}) + GRAD_W'(ofs_r);
  end

  // ---------------- squares, sum, root ----------------
  logic [SQ_W-1:0]  sqx_r, sqy_r;
  logic [SUM_W-1:0] sum;
  logic             sat_r;
  logic             root_start;
  logic             root_done;
  pixel_t           root_val;
  pixel_t           mag_r;

  assign sum        = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign root_start = (state_r == S_SUM);

  pem_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .operand (sum[ROOT_IN_W-1:0]),
    .done    (root_done),
    .root    (root_val)
  );

  always_ff @(posedge clk) begin
    if (in_go) begin
      ra_r <= cur_r;
      ca_r <= cur_c;
      px_r <= in_pix.pixel;
    end
    if (state_r == S_READ) begin
      top_r  <= (ra_r == ROW_W'(1));
      left_r <= (ca_r == COL_W'(1));
    end
    if (state_r == S_GRAD) begin
      gx_r   <= gx;
      gy_r   <= gy;
      orow_r <= orow;
      ocol_r <= ocol;
      last_r <= ((mask_r & (mask_r - 1'b1)) == '0);
    end
    if (state_r == S_SQR) begin
      sqx_r <= SQ_W'(gx_r * gx_r);
      sqy_r <= SQ_W'(gy_r * gy_r);
    end
    if (state_r == S_SUM) begin
      sat_r <= (sum > SAT_LIMIT);
    end
    if ((state_r == S_ROOT) && root_done) begin
      mag_r <= sat_r ? PIX_MAX : root_val;
    end
  end

  // ---------------- output register ----------------
  logic   emit_go;
  logic   out_valid_r;
  pixel_t out_val_r;
  row_t   out_row_r;
  col_t   out_col_r;
  logic   out_end_r;

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_val_r <= mag_r;
      out_row_r <= orow_r;
      out_col_r <= ocol_r;
      out_end_r <= last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.edge_value = out_val_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.run_end    = out_end_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    unique case (state_r)
      S_IDLE: if (in_go) state_nxt = S_READ;
      S_READ: begin
        mask_nxt  = need;
        state_nxt = (need != '0) ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        mask_nxt  = mask_r & (mask_r - 1'b1);  // drop the lowest pending result
        state_nxt = S_SQR;
      end
      S_SQR:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ROOT;
      S_ROOT: if (root_done) state_nxt = S_EMIT;
      S_EMIT: if (emit_go) state_nxt = (mask_r != '0) ? S_GRAD : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mask_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (DIM_W'(col_r) < eff_w) && (DIM_W'(row_r) < eff_h))
    else $error("scan position outside the image");

  a_grad_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRAD) |-> (mask_r != '0))
    else $error("gradient step with no pending result");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_res.run_end ? (state_r == S_IDLE) : (state_r == S_GRAD)))
    else $error("run end flag disagrees with pending results");

  a_root_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT))
    else $error("root unit finished outside its wait state");

endmodule

`default_nettype wire
